/* design/ptzfb_pkg.sv */
// ptzfb_pkg: shared types, register defaults and the verb table for the
// pan/tilt/zoom frame builder. No dependencies.

package ptzfb_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_SYNC_BYTE      = 3'd0;
   localparam logic [2:0] CSR_DEVICE_ADDRESS = 3'd1;
   localparam logic [2:0] CSR_TERM_ENABLE    = 3'd2;
   localparam logic [2:0] CSR_TERM_BYTE      = 3'd3;
   localparam logic [2:0] CSR_CHECKSUM_MODE  = 3'd4;
   localparam logic [2:0] CSR_DEFAULT_SPEED  = 3'd5;
   localparam logic [2:0] CSR_AUX_ENABLE     = 3'd6;
   localparam logic [2:0] CSR_PRESET_ENABLE  = 3'd7;

   localparam logic [7:0] RST_SYNC_BYTE      = 8'hc5;
   localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h01;
   localparam logic       RST_TERM_ENABLE    = 1'b1;
   localparam logic [7:0] RST_TERM_BYTE      = 8'h5c;
   localparam logic       RST_CHECKSUM_MODE  = 1'b0;
   localparam logic [5:0] RST_DEFAULT_SPEED  = 6'd63;
   localparam logic       RST_AUX_ENABLE     = 1'b0;
   localparam logic       RST_PRESET_ENABLE  = 1'b0;

   // operations and verbs
   localparam logic       OP_VERB   = 1'b0;
   localparam logic       OP_PRESET = 1'b1;
   localparam logic [3:0] VERB_STOP  = 4'd0;
   localparam logic [3:0] VERB_NEAR  = 4'd1;
   localparam logic [3:0] VERB_FAR   = 4'd2;
   localparam logic [3:0] VERB_TELE  = 4'd3;
   localparam logic [3:0] VERB_WIDE  = 4'd4;
   localparam logic [3:0] VERB_UP    = 4'd5;
   localparam logic [3:0] VERB_DOWN  = 4'd6;
   localparam logic [3:0] VERB_LEFT  = 4'd7;
   localparam logic [3:0] VERB_RIGHT = 4'd8;
   localparam logic [3:0] VERB_DAY   = 4'd9;
   localparam logic [3:0] VERB_NIGHT = 4'd10;

   localparam logic [7:0] PRESET_CMD = 8'h07;
   localparam logic [7:0] SPEED_MAX  = 8'd63;

   // speed slot of a verb
   localparam logic [1:0] SLOT_NONE = 2'd0;
   localparam logic [1:0] SLOT_PAN  = 2'd1;
   localparam logic [1:0] SLOT_TILT = 2'd2;

   // byte positions within a frame
   localparam logic [2:0] POS_SYNC     = 3'd0;
   localparam logic [2:0] POS_ADDRESS  = 3'd1;
   localparam logic [2:0] POS_CMD1     = 3'd2;
   localparam logic [2:0] POS_CMD2     = 3'd3;
   localparam logic [2:0] POS_DATA1    = 3'd4;
   localparam logic [2:0] POS_DATA2    = 3'd5;
   localparam logic [2:0] POS_CHECKSUM = 3'd6;
   localparam logic [2:0] POS_TERM     = 3'd7;

   // floor(sum / 100) as (sum * 41) >> 12, exact for sums below 1000
   localparam int          SUM_W      = 10;
   localparam logic [5:0]  RECIP_100  = 6'd41;
   localparam int          RECIP_SHIFT = 12;
   localparam logic [6:0]  MOD_BASE   = 7'd100;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       operation;
      logic [3:0] verb;
      logic [7:0] speed;
      logic [7:0] preset;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       refused;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] device_address;
      logic       terminator_enable;
      logic [7:0] terminator_byte;
      logic       checksum_mode;
      logic [5:0] default_speed;
      logic       aux_enable;
      logic       preset_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] dat1;
      logic [7:0] dat2;
      logic [1:0] slot;
   } verb_entry_type;

   // one classified command, ready to be serialized
   typedef struct packed {
      logic       refused;
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] dat1;
      logic [7:0] dat2;
      logic [7:0] checksum;
   } frame_type;

   function automatic verb_entry_type verb_lookup(input logic [3:0] verb);
      verb_entry_type e;
      e = '{cmd1: 8'h00, cmd2: 8'h00, dat1: 8'h00, dat2: 8'h00, slot: SLOT_NONE};
      case (verb)
         VERB_STOP:  e.cmd2 = 8'h00;
         VERB_NEAR:  e.cmd1 = 8'h01;
         VERB_FAR:   e.cmd2 = 8'h80;
         VERB_TELE:  e.cmd2 = 8'h20;
         VERB_WIDE:  e.cmd2 = 8'h40;
         VERB_UP: begin
            e.cmd2 = 8'h08;
            e.slot = SLOT_TILT;
         end
         VERB_DOWN: begin
            e.cmd2 = 8'h10;
            e.slot = SLOT_TILT;
         end
         VERB_LEFT: begin
            e.cmd2 = 8'h04;
            e.slot = SLOT_PAN;
         end
         VERB_RIGHT: begin
            e.cmd2 = 8'h02;
            e.slot = SLOT_PAN;
         end
         VERB_DAY: begin
            e.cmd2 = 8'h0b;
            e.dat2 = 8'h01;
         end
         VERB_NIGHT: begin
            e.cmd2 = 8'h09;
            e.dat2 = 8'h01;
         end
         default: e.cmd2 = 8'h00;
      endcase
      return e;
   endfunction

endpackage

/* design/ptzfb_front.sv */
// ptzfb_front: accepts commands, checks them against the enables, fills in
// the speed and computes the checksum. Depends on ptzfb_pkg.

module ptzfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ptzfb_pkg::req_type  req_data,
   input  ptzfb_pkg::cfg_type  cfg,
   output logic                push_valid,
   input  logic                push_stall,
   output ptzfb_pkg::frame_type push_data
);

   logic                         valid_ff, valid_in;
   logic                         refused_ff, refused_in;
   logic                         mode_ff, mode_in;
   logic [7:0]                   cmd1_ff, cmd1_in, cmd2_ff, cmd2_in;
   logic [7:0]                   dat1_ff, dat1_in, dat2_ff, dat2_in;
   logic [ptzfb_pkg::SUM_W-1:0]  sum_ff, sum_in;
   ptzfb_pkg::verb_entry_type    entry;
   logic [7:0]                   spd;
   logic                         accept;
   logic [15:0]                  recip_prod;
   logic [2:0]                   quot;
   logic [ptzfb_pkg::SUM_W-1:0]  rem;

   assign req_stall = valid_ff && push_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      entry = ptzfb_pkg::verb_lookup(req_data.verb);
      if (req_data.speed == 8'd0) begin
         spd = {2'b00, cfg.default_speed};
      end else if (req_data.speed > ptzfb_pkg::SPEED_MAX) begin
         spd = ptzfb_pkg::SPEED_MAX;
      end else begin
         spd = req_data.speed;
      end

      refused_in = 1'b0;
      cmd1_in    = entry.cmd1;
      cmd2_in    = entry.cmd2;
      dat1_in    = entry.dat1;
      dat2_in    = entry.dat2;
      if (req_data.operation == ptzfb_pkg::OP_PRESET) begin
         refused_in = !cfg.preset_enable;
         cmd1_in    = 8'h00;
         cmd2_in    = ptzfb_pkg::PRESET_CMD;
         dat1_in    = 8'h00;
         dat2_in    = req_data.preset;
      end else begin
         if (req_data.verb > ptzfb_pkg::VERB_NIGHT) begin
            refused_in = 1'b1;
         end else if ((req_data.verb == ptzfb_pkg::VERB_DAY ||
                       req_data.verb == ptzfb_pkg::VERB_NIGHT) && !cfg.aux_enable) begin
            refused_in = 1'b1;
         end
         if (entry.slot == ptzfb_pkg::SLOT_PAN) begin
            dat1_in = spd;
         end else if (entry.slot == ptzfb_pkg::SLOT_TILT) begin
            dat2_in = spd;
         end
      end
      mode_in = cfg.checksum_mode;
      sum_in  = {2'b00, cfg.device_address} + {2'b00, cmd1_in} + {2'b00, cmd2_in}
              + {2'b00, dat1_in} + {2'b00, dat2_in};
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !push_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         refused_ff <= refused_in;
         mode_ff    <= mode_in;
         cmd1_ff    <= cmd1_in;
         cmd2_ff    <= cmd2_in;
         dat1_ff    <= dat1_in;
         dat2_ff    <= dat2_in;
         sum_ff     <= sum_in;
      end
   end

   // sum mod 100 through a reciprocal multiply, sum stays below 1000
   always_comb begin
      recip_prod = {6'b0, sum_ff} * {10'b0, ptzfb_pkg::RECIP_100};
      quot       = recip_prod[ptzfb_pkg::RECIP_SHIFT +: 3];
      rem        = sum_ff - ({7'b0, quot} * {3'b0, ptzfb_pkg::MOD_BASE});
   end

   assign push_valid         = valid_ff;
   assign push_data.refused  = refused_ff;
   assign push_data.cmd1     = cmd1_ff;
   assign push_data.cmd2     = cmd2_ff;
   assign push_data.dat1     = dat1_ff;
   assign push_data.dat2     = dat2_ff;
   assign push_data.checksum = mode_ff ? sum_ff[7:0] : rem[7:0];

endmodule

/* design/ptzfb_queue.sv */
// ptzfb_queue: short first-in first-out queue of classified frames between
// the front and back parts. Depends on ptzfb_pkg.

module ptzfb_queue #(
   parameter int DEPTH = ptzfb_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_stall,
   input  ptzfb_pkg::frame_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_take,
   output ptzfb_pkg::frame_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ptzfb_pkg::frame_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_stall = (count_ff == FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_take && pop_valid;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/ptzfb_back.sv */
// ptzfb_back: serializes the frame at the head of the queue, one byte per
// transaction, into the output register. Depends on ptzfb_pkg.

module ptzfb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ptzfb_pkg::cfg_type   cfg,
   input  logic                 pop_valid,
   output logic                 pop_take,
   input  ptzfb_pkg::frame_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ptzfb_pkg::rsp_type   rsp_data
);

   logic [2:0]          pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ptzfb_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic                load;

   assign load = pop_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in.refused   = pop_data.refused;
      rsp_data_in.last_byte = 1'b0;
      case (pos_ff)
         ptzfb_pkg::POS_SYNC:     rsp_data_in.frame_byte = cfg.sync_byte;
         ptzfb_pkg::POS_ADDRESS:  rsp_data_in.frame_byte = cfg.device_address;
         ptzfb_pkg::POS_CMD1:     rsp_data_in.frame_byte = pop_data.cmd1;
         ptzfb_pkg::POS_CMD2:     rsp_data_in.frame_byte = pop_data.cmd2;
         ptzfb_pkg::POS_DATA1:    rsp_data_in.frame_byte = pop_data.dat1;
         ptzfb_pkg::POS_DATA2:    rsp_data_in.frame_byte = pop_data.dat2;
         ptzfb_pkg::POS_CHECKSUM: rsp_data_in.frame_byte = pop_data.checksum;
         ptzfb_pkg::POS_TERM:     rsp_data_in.frame_byte = cfg.terminator_byte;
         default:                 rsp_data_in.frame_byte = 8'h00;
      endcase
      if (pop_data.refused) begin
         rsp_data_in.frame_byte = 8'h00;
         rsp_data_in.last_byte  = 1'b1;
      end else if (pos_ff == ptzfb_pkg::POS_TERM) begin
         rsp_data_in.last_byte = 1'b1;
      end else if (pos_ff == ptzfb_pkg::POS_CHECKSUM && !cfg.terminator_enable) begin
         rsp_data_in.last_byte = 1'b1;
      end

      pop_take = load && rsp_data_in.last_byte;
      pos_in   = pos_ff;
      if (load) begin
         pos_in = rsp_data_in.last_byte ? ptzfb_pkg::POS_SYNC : pos_ff + 3'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= ptzfb_pkg::POS_SYNC;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/ptz_command_frame_builder_core.sv */
// ptz_command_frame_builder_core: pan/tilt/zoom command to serial frame bytes.
// Path: the first byte of a transaction's frame passes through the front register, the
// queue and the output register. Throughput: one output byte per cycle while rsp_stall
// is low; a frame is 7 or 8 bytes and a refusal 1 byte, the output register sets this.
// Up to QUEUE_DEPTH commands wait in the queue.
// Reset: synchronous, empties the queue and restores all register defaults.

module ptz_command_frame_builder_core #(
   parameter int QUEUE_DEPTH = ptzfb_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ptzfb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ptzfb_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_write_data
);

   ptzfb_pkg::cfg_type   cfg_ff, cfg_in;
   logic                 push_valid, push_stall;
   ptzfb_pkg::frame_type push_data;
   logic                 pop_valid, pop_take;
   ptzfb_pkg::frame_type pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ptzfb_pkg::CSR_SYNC_BYTE:      cfg_in.sync_byte         = csr_write_data;
            ptzfb_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address    = csr_write_data;
            ptzfb_pkg::CSR_TERM_ENABLE:    cfg_in.terminator_enable = csr_write_data[0];
            ptzfb_pkg::CSR_TERM_BYTE:      cfg_in.terminator_byte   = csr_write_data;
            ptzfb_pkg::CSR_CHECKSUM_MODE:  cfg_in.checksum_mode     = csr_write_data[0];
            ptzfb_pkg::CSR_DEFAULT_SPEED:  cfg_in.default_speed     = csr_write_data[5:0];
            ptzfb_pkg::CSR_AUX_ENABLE:     cfg_in.aux_enable        = csr_write_data[0];
            ptzfb_pkg::CSR_PRESET_ENABLE:  cfg_in.preset_enable     = csr_write_data[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte         <= ptzfb_pkg::RST_SYNC_BYTE;
         cfg_ff.device_address    <= ptzfb_pkg::RST_DEVICE_ADDRESS;
         cfg_ff.terminator_enable <= ptzfb_pkg::RST_TERM_ENABLE;
         cfg_ff.terminator_byte   <= ptzfb_pkg::RST_TERM_BYTE;
         cfg_ff.checksum_mode     <= ptzfb_pkg::RST_CHECKSUM_MODE;
         cfg_ff.default_speed     <= ptzfb_pkg::RST_DEFAULT_SPEED;
         cfg_ff.aux_enable        <= ptzfb_pkg::RST_AUX_ENABLE;
         cfg_ff.preset_enable     <= ptzfb_pkg::RST_PRESET_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptzfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data)
   );

   ptzfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   ptzfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_take  (pop_take),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
